FILE: rtl/bmp_pkg.sv
// bmp_pkg: shared constants, query record and fill-sequencer states for the
// binomial-mod-prime block. No dependencies.

package bmp_pkg;

    localparam int IN_W  = 12;
    localparam int RES_W = 30;

    // Modulus and the exponent used for the Fermat inverse of the last factorial
    localparam logic [RES_W-1:0] PRIME   = 30'd1000000007;
    localparam logic [RES_W-1:0] INV_EXP = PRIME - 30'd2;

    // Barrett constant floor(2^60 / PRIME), fits in 31 bits
    localparam int               BARRETT_W    = 31;
    localparam logic [63:0]      BARRETT_WIDE = (64'd1 << 60) / 64'(PRIME);
    localparam logic [BARRETT_W-1:0] BARRETT_M = BARRETT_WIDE[BARRETT_W-1:0];

    // Modular multiplier pipeline depth, queue and output buffer depths
    localparam int MUL_LAT     = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 16;

    // Classified request as handed from the front end to the back end
    typedef struct packed {
        logic            zero;
        logic [IN_W-1:0] total;
        logic [IN_W-1:0] chosen;
        logic [IN_W-1:0] diff;
    } query_t;

    typedef enum logic [2:0] {
        ST_FACT_WRITE,
        ST_FACT_WAIT,
        ST_POW_ISSUE,
        ST_POW_WAIT,
        ST_INV_WRITE,
        ST_INV_WAIT,
        ST_RUN
    } fill_state_t;

endpackage

FILE: rtl/bmp_modmul.sv
// bmp_modmul: five-stage pipelined multiplier modulo PRIME (Barrett reduction).
// Depends on bmp_pkg for PRIME, BARRETT_M and MUL_LAT.

module bmp_modmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bmp_pkg::RES_W-1:0]   a,
    input  logic [bmp_pkg::RES_W-1:0]   b,
    output logic                        out_valid,
    output logic [bmp_pkg::RES_W-1:0]   result
);

    localparam logic [31:0] P1 = 32'(bmp_pkg::PRIME);
    localparam logic [31:0] P2 = P1 << 1;

    logic [bmp_pkg::MUL_LAT-1:0] vld_reg;
    logic [bmp_pkg::MUL_LAT-1:0] vld_next;

    logic [59:0]               prod_reg;
    logic [61:0]               est_reg;
    logic [31:0]               low_s2_reg;
    logic [31:0]               low_s3_reg;
    logic [31:0]               qp_reg;
    logic [31:0]               rem_reg;
    logic [bmp_pkg::RES_W-1:0] result_reg;

    logic [59:0]               prod_next;
    logic [61:0]               est_next;
    logic [61:0]               qp_full;
    logic [31:0]               rem_next;
    logic [bmp_pkg::RES_W-1:0] result_next;

    assign vld_next = {vld_reg[bmp_pkg::MUL_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        prod_next = 60'(a) * 60'(b);
        // quotient estimate from the top 31 bits, at most two short of the truth
        est_next  = 62'(prod_reg[59:29]) * 62'(bmp_pkg::BARRETT_M);
        qp_full   = 62'(est_reg[61:31]) * 62'(bmp_pkg::PRIME);
        rem_next  = low_s3_reg - qp_reg;
        priority if (rem_reg >= P2)
        begin
            result_next = bmp_pkg::RES_W'(rem_reg - P2);
        end
        else if (rem_reg >= P1)
        begin
            result_next = bmp_pkg::RES_W'(rem_reg - P1);
        end
        else
        begin
            result_next = bmp_pkg::RES_W'(rem_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        est_reg    <= est_next;
        low_s2_reg <= prod_reg[31:0];
        low_s3_reg <= low_s2_reg;
        qp_reg     <= qp_full[31:0];
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    assign out_valid = vld_reg[bmp_pkg::MUL_LAT-1];
    assign result    = result_reg;

endmodule

FILE: rtl/bmp_fifo.sv
// bmp_fifo: small show-ahead FIFO with valid/ready on both sides.
// No package dependencies.

module bmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/bmp_front.sv
// bmp_front: request intake stage; checks range, forms n - k, registers the
// classified request for the queue. Depends on bmp_pkg (query_t, IN_W).

module bmp_front #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [bmp_pkg::IN_W-1:0] total,
    input  logic [bmp_pkg::IN_W-1:0] chosen,
    input  logic                     tables_ready,
    output logic                     q_valid,
    input  logic                     q_ready,
    output bmp_pkg::query_t          q_data
);

    logic            valid_reg;
    logic            valid_next;
    bmp_pkg::query_t data_reg;
    bmp_pkg::query_t data_next;
    logic            accept;
    logic            out_of_range;
    logic            zero;

    assign in_ready = tables_ready && (!valid_reg || q_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        out_of_range = (32'(total) >= 32'(TABLE_SIZE));
        zero         = (chosen > total) || out_of_range;
        // steer dead requests to entry zero so every table read is defined
        data_next.zero   = zero;
        data_next.total  = zero ? '0 : total;
        data_next.chosen = zero ? '0 : chosen;
        data_next.diff   = zero ? '0 : total - chosen;

        priority if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

FILE: rtl/bmp_back.sv
// bmp_back: factorial and inverse-factorial tables, their fill sequencer after
// reset, the two-multiply lookup pipeline and the output buffer.
// Depends on bmp_pkg, bmp_modmul and bmp_fifo.

module bmp_back #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  bmp_pkg::query_t           q_data,
    output logic                      tables_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bmp_pkg::RES_W-1:0] value
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CRED_W = $clog2(bmp_pkg::OUT_DEPTH + 1);
    localparam int RW     = bmp_pkg::RES_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // Tables
    logic [RW-1:0] fact_mem [TABLE_SIZE];
    logic [RW-1:0] inv_mem  [TABLE_SIZE];

    // Fill sequencer
    bmp_pkg::fill_state_t state_reg;
    bmp_pkg::fill_state_t state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [IDX_W-1:0]     idx_inc;
    logic [RW-1:0]        acc_reg;
    logic [RW-1:0]        acc_next;
    logic [RW-1:0]        base_reg;
    logic [RW-1:0]        base_next;
    logic [RW-1:0]        pow_reg;
    logic [RW-1:0]        pow_next;
    logic [RW-1:0]        exp_reg;
    logic [RW-1:0]        exp_next;
    logic                 fact_we;
    logic                 inv_we;
    logic                 fill_a_vld;
    logic [RW-1:0]        fill_a_x;
    logic [RW-1:0]        fill_a_y;
    logic                 fill_b_vld;
    logic [RW-1:0]        fill_b_x;
    logic [RW-1:0]        fill_b_y;
    logic                 run;

    // Lookup pipeline
    logic                 pop;
    logic                 rd_valid_reg;
    logic                 zero_rd_reg;
    logic [RW-1:0]        fact_rd_reg;
    logic [RW-1:0]        invk_rd_reg;
    logic [RW-1:0]        invd_rd_reg;
    logic [RW-1:0]        fact_dly_reg [bmp_pkg::MUL_LAT];
    logic [CRED_W-1:0]    credit_reg;
    logic [CRED_W-1:0]    credit_next;

    // Multipliers
    logic                 mula_in_vld;
    logic [RW-1:0]        mula_x;
    logic [RW-1:0]        mula_y;
    logic                 mula_vld;
    logic [RW-1:0]        mula_res;
    logic                 mulb_in_vld;
    logic [RW-1:0]        mulb_x;
    logic [RW-1:0]        mulb_y;
    logic                 mulb_vld;
    logic [RW-1:0]        mulb_res;

    assign run          = (state_reg == bmp_pkg::ST_RUN);
    assign tables_ready = run;
    assign idx_inc      = idx_reg + 1'b1;

    // Fill: factorials upward, Fermat inverse of the last one, then
    // inverse factorials downward by inv_fact[i-1] = inv_fact[i] * i.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        pow_next   = pow_reg;
        exp_next   = exp_reg;
        fact_we    = 1'b0;
        inv_we     = 1'b0;
        fill_a_vld = 1'b0;
        fill_a_x   = acc_reg;
        fill_a_y   = '0;
        fill_b_vld = 1'b0;
        fill_b_x   = pow_reg;
        fill_b_y   = base_reg;

        unique case (state_reg)
            bmp_pkg::ST_FACT_WRITE:
            begin
                fact_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    base_next  = acc_reg;
                    pow_next   = RW'(1);
                    exp_next   = bmp_pkg::INV_EXP;
                    state_next = bmp_pkg::ST_POW_ISSUE;
                end
                else
                begin
                    fill_a_vld = 1'b1;
                    fill_a_y   = RW'(idx_inc);
                    idx_next   = idx_inc;
                    state_next = bmp_pkg::ST_FACT_WAIT;
                end
            end
            bmp_pkg::ST_FACT_WAIT:
            begin
                if (mula_vld)
                begin
                    acc_next   = mula_res;
                    state_next = bmp_pkg::ST_FACT_WRITE;
                end
            end
            bmp_pkg::ST_POW_ISSUE:
            begin
                if (exp_reg == '0)
                begin
                    acc_next   = pow_reg;
                    idx_next   = LAST_IDX;
                    state_next = bmp_pkg::ST_INV_WRITE;
                end
                else
                begin
                    fill_a_vld = 1'b1;
                    fill_a_x   = base_reg;
                    fill_a_y   = base_reg;
                    fill_b_vld = 1'b1;
                    state_next = bmp_pkg::ST_POW_WAIT;
                end
            end
            bmp_pkg::ST_POW_WAIT:
            begin
                if (mula_vld)
                begin
                    base_next = mula_res;
                    if (exp_reg[0])
                    begin
                        pow_next = mulb_res;
                    end
                    exp_next   = exp_reg >> 1;
                    state_next = bmp_pkg::ST_POW_ISSUE;
                end
            end
            bmp_pkg::ST_INV_WRITE:
            begin
                inv_we = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = bmp_pkg::ST_RUN;
                end
                else
                begin
                    fill_a_vld = 1'b1;
                    fill_a_y   = RW'(idx_reg);
                    idx_next   = idx_reg - 1'b1;
                    state_next = bmp_pkg::ST_INV_WAIT;
                end
            end
            bmp_pkg::ST_INV_WAIT:
            begin
                if (mula_vld)
                begin
                    acc_next   = mula_res;
                    state_next = bmp_pkg::ST_INV_WRITE;
                end
            end
            bmp_pkg::ST_RUN:
            begin
                state_next = bmp_pkg::ST_RUN;
            end
            default:
            begin
                state_next = bmp_pkg::ST_FACT_WRITE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmp_pkg::ST_FACT_WRITE;
            idx_reg   <= '0;
            acc_reg   <= RW'(1);
            base_reg  <= '0;
            pow_reg   <= '0;
            exp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            pow_reg   <= pow_next;
            exp_reg   <= exp_next;
        end
    end

    // Credits cover every request between the queue pop and the output port
    assign q_ready     = run && (credit_reg < CRED_W'(bmp_pkg::OUT_DEPTH));
    assign pop         = q_valid && q_ready;
    assign credit_next = credit_reg + CRED_W'(pop) - CRED_W'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            rd_valid_reg <= pop;
        end
    end

    // Table write port
    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[idx_reg] <= acc_reg;
        end
        if (inv_we)
        begin
            inv_mem[idx_reg] <= acc_reg;
        end
    end

    // Table read ports, registered
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fact_rd_reg <= fact_mem[IDX_W'(q_data.total)];
            invk_rd_reg <= inv_mem[IDX_W'(q_data.chosen)];
            invd_rd_reg <= inv_mem[IDX_W'(q_data.diff)];
            zero_rd_reg <= q_data.zero;
        end
    end

    // Hold n! alongside the first multiply
    always_ff @(posedge clk)
    begin
        fact_dly_reg[0] <= fact_rd_reg;
        for (int i = 1; i < bmp_pkg::MUL_LAT; i++)
        begin
            fact_dly_reg[i] <= fact_dly_reg[i-1];
        end
    end

    always_comb
    begin
        if (run)
        begin
            mula_in_vld = rd_valid_reg;
            mula_x      = zero_rd_reg ? '0 : invk_rd_reg;
            mula_y      = invd_rd_reg;
            mulb_in_vld = mula_vld;
            mulb_x      = fact_dly_reg[bmp_pkg::MUL_LAT-1];
            mulb_y      = mula_res;
        end
        else
        begin
            mula_in_vld = fill_a_vld;
            mula_x      = fill_a_x;
            mula_y      = fill_a_y;
            mulb_in_vld = fill_b_vld;
            mulb_x      = fill_b_x;
            mulb_y      = fill_b_y;
        end
    end

    bmp_modmul u_mula (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mula_in_vld),
        .a         (mula_x),
        .b         (mula_y),
        .out_valid (mula_vld),
        .result    (mula_res)
    );

    bmp_modmul u_mulb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mulb_in_vld),
        .a         (mulb_x),
        .b         (mulb_y),
        .out_valid (mulb_vld),
        .result    (mulb_res)
    );

    bmp_fifo #(
        .WIDTH (RW),
        .DEPTH (bmp_pkg::OUT_DEPTH)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (run && mulb_vld),
        .push_ready (),
        .push_data  (mulb_res),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (value)
    );

endmodule

FILE: rtl/binomial_mod_prime_top.sv
// binomial_mod_prime_top: n choose k modulo 1000000007 from factorial tables.
// Depends on bmp_pkg, bmp_front, bmp_fifo, bmp_back (bmp_modmul below it).
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | total[11:0] (n), chosen[11:0] (k)
//  output  | out_valid / out_ready| value[29:0] = C(n,k) mod 1000000007
//
// Throughput is one request per cycle once the tables are built and while output
// credits remain; each request passes two five-stage modular multipliers
// after a registered table read.
// After reset the tables are built by the fill sequencer through the shared
// multipliers, with in_ready low throughout.
// The output buffer holds 16 results; requests keep flowing under output
// stalls until its credits run out, then the queue and front stage fill.

module binomial_mod_prime_top #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bmp_pkg::IN_W-1:0]  total,
    input  logic [bmp_pkg::IN_W-1:0]  chosen,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bmp_pkg::RES_W-1:0] value
);

    localparam int QW = $bits(bmp_pkg::query_t);

    // front -> queue
    logic            fq_valid;
    logic            fq_ready;
    bmp_pkg::query_t fq_data;
    // queue -> back
    logic            qb_valid;
    logic            qb_ready;
    logic [QW-1:0]   qb_bits;
    bmp_pkg::query_t qb_data;
    // back -> front: tables built
    logic            tables_ready;

    assign qb_data = bmp_pkg::query_t'(qb_bits);

    // Intake: range check, n - k, stall while tables are being built
    bmp_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .total        (total),
        .chosen       (chosen),
        .tables_ready (tables_ready),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    // Decouple intake from the lookup pipeline
    bmp_fifo #(
        .WIDTH (QW),
        .DEPTH (bmp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_bits)
    );

    // Tables, multipliers and output buffer
    bmp_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .tables_ready (tables_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value)
    );

endmodule
